FILE: sv/rms_velocity_from_depth_time_unit_assert.svh
// Assertion macros for the RMS velocity unit
`ifndef RMS_VELOCITY_FROM_DEPTH_TIME_UNIT_ASSERT_SVH
`define RMS_VELOCITY_FROM_DEPTH_TIME_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define RVD_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// implication whose consequent is checked on the next clock edge
`define RVD_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

FILE: sv/rvd_pkg.sv
package rvd_pkg;
   localparam int unsigned VelMax = 65535;
   localparam int unsigned TwoWay = 2000;
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DIFF = 4'd1;
   localparam logic [3:0] ST_MULA = 4'd2;
   localparam logic [3:0] ST_DIVV = 4'd3;
   localparam logic [3:0] ST_SQ = 4'd4;
   localparam logic [3:0] ST_SUM1 = 4'd5;
   localparam logic [3:0] ST_SUM2 = 4'd6;
   localparam logic [3:0] ST_DIVT = 4'd7;
   localparam logic [3:0] ST_SQRT = 4'd8;
   localparam logic [3:0] ST_OUT = 4'd9;
   localparam logic [3:0] ST_MULB = 4'd10;
   localparam logic [3:0] ST_MULC = 4'd11;
   localparam logic [3:0] ST_SQ2 = 4'd12;
   localparam logic [0:0] REG_TIME_STEP = 1'b0;
   localparam logic [0:0] REG_FIRST_TIME = 1'b1;
   typedef struct packed {
      logic [16:0] rms_velocity;
      logic last_of_run;
      logic saturated;
   } rsp_type;
   typedef struct packed {
      logic [31:0] depth;
      logic start_of_trace;
   } req_type;
endpackage

FILE: sv/rvd_stream_if.sv
interface rvd_stream_if #(parameter int unsigned W = 1);
   logic valid;
   logic ready;
   logic [W-1:0] payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

FILE: sv/rms_velocity_from_depth_time_unit.sv
// channel | role   | payload
// req     | sink   | depth (s32), start_of_trace
// rsp     | source | rms_velocity (s17), last_of_run, saturated
// csr     | APB    | 0x0 time_step (16b), 0x4 first_time (24b)
// A trace's first sample only starts the trace and gives no result. A later sample passes
// through a divide by time_step, a divide by elapsed time and a square root on restoring
// shift units, with one 32x32 multiplier reused.
// Reset is synchronous and clears all trace state. A result waits in the output register;
// the next request is taken once the sequencer is idle, and a result that is due while
// another still waits stalls the sequencer until the waiting one has gone.
module rms_velocity_from_depth_time_unit (
   input  logic clock,
   input  logic reset,
   rvd_stream_if.sink req,
   rvd_stream_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   logic [3:0] state_ff, state_in;
   logic [15:0] tstep_ff, tstep_in;
   logic [23:0] ftime_ff, ftime_in;
   logic [31:0] prev_ff, prev_in;
   logic [63:0] sum_ff, sum_in;
   logic [31:0] elap_ff, elap_in;
   logic [1:0] phase_ff, phase_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic [6:0] cnt_ff, cnt_in;
   logic neg_ff, neg_in;
   logic sat_ff, sat_in;
   logic sat0_ff, sat0_in;
   logic first_ff, first_in;
   logic [16:0] vel_ff, vel_in;
   logic [63:0] sq_ff, sq_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] ma_ff, ma_in, mb_ff, mb_in;
   logic [63:0] prod;
   logic [64:0] trial;
   logic [65:0] sqt;
   logic [63:0] wide_sum;
   logic wide_c;
   logic [15:0] step;
   logic [32:0] tnext;
   logic [32:0] diff;
   logic rv_ff, rv_in;
   rvd_pkg::rsp_type out_ff, out_in;
   rvd_pkg::req_type rq;
   logic csr_wr;

   assign rq = req.payload;
   assign step = (tstep_ff == 16'd0) ? 16'd1 : tstep_ff;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == rvd_pkg::REG_FIRST_TIME) ? {8'd0, ftime_ff}
                                                                  : {16'd0, tstep_ff};
   assign req.ready = (state_ff == rvd_pkg::ST_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.payload = out_ff;
   assign prod = {32'd0, ma_ff} * {32'd0, mb_ff};
   assign trial = {rem_ff, num_ff[63]} - {1'b0, den_ff};
   assign sqt = {rem_ff, num_ff[63:62]} - {quo_ff, 2'b01};
   assign {wide_c, wide_sum} = {1'b0, sum_ff} + {1'b0, acc_ff};
   assign tnext = {1'b0, elap_ff} + {17'd0, step};
   assign diff = {rq.depth[31], rq.depth} - {prev_ff[31], prev_ff};

   always_comb begin
      state_in = state_ff; tstep_in = tstep_ff; ftime_in = ftime_ff;
      prev_in = prev_ff; sum_in = sum_ff; elap_in = elap_ff; phase_in = phase_ff;
      num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      cnt_in = cnt_ff; neg_in = neg_ff; sat_in = sat_ff; sat0_in = sat0_ff;
      first_in = first_ff; vel_in = vel_ff; sq_in = sq_ff; acc_in = acc_ff;
      ma_in = ma_ff; mb_in = mb_ff; rv_in = rv_ff; out_in = out_ff;
      if (rv_ff && rsp.ready) begin
         rv_in = 1'b0;
      end
      if (csr_wr) begin
         if (csr_paddr[2] == rvd_pkg::REG_TIME_STEP) begin
            tstep_in = csr_pwdata[15:0];
         end else begin
            ftime_in = csr_pwdata[23:0];
         end
      end
      unique case (state_ff)
         rvd_pkg::ST_IDLE: begin
            if (req.valid) begin
               prev_in = rq.depth;
               if (rq.start_of_trace || phase_ff == 2'd0 || phase_ff == 2'd3) begin
                  sum_in = 64'd0; elap_in = 32'd0; phase_in = 2'd1;
               end else begin
                  first_in = (phase_ff == 2'd1);
                  neg_in = diff[32];
                  ma_in = diff[32] ? 32'(-diff) : diff[31:0];
                  mb_in = 32'(rvd_pkg::TwoWay);
                  sat_in = 1'b0;
                  state_in = rvd_pkg::ST_MULA;
               end
            end
         end
         rvd_pkg::ST_MULA: begin
            num_in = prod + {49'd0, step[15:1]};
            rem_in = 64'd0; quo_in = 64'd0; den_in = {48'd0, step}; cnt_in = 7'd64;
            state_in = rvd_pkg::ST_DIVV;
         end
         rvd_pkg::ST_DIVV: begin
            if (cnt_ff == 7'd0) begin
               if (!neg_ff && quo_ff > 64'(rvd_pkg::VelMax)) begin
                  sat_in = 1'b1; vel_in = 17'h0FFFF; ma_in = 32'd65535;
               end else if (neg_ff && quo_ff > 64'd65536) begin
                  sat_in = 1'b1; vel_in = 17'h10000; ma_in = 32'd65536;
               end else begin
                  vel_in = neg_ff ? 17'(-quo_ff) : quo_ff[16:0];
                  ma_in = quo_ff[31:0];
               end
               mb_in = (!neg_ff && quo_ff > 64'(rvd_pkg::VelMax)) ? 32'd65535 :
                       (neg_ff && quo_ff > 64'd65536) ? 32'd65536 : quo_ff[31:0];
               state_in = rvd_pkg::ST_SQ;
            end else begin
               cnt_in = cnt_ff - 7'd1;
               num_in = {num_ff[62:0], 1'b0};
               if (!trial[64]) begin
                  rem_in = trial[63:0]; quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[62:0], num_ff[63]}; quo_in = {quo_ff[62:0], 1'b0};
               end
            end
         end
         rvd_pkg::ST_SQ: begin
            sq_in = prod;
            sat0_in = sat_ff;
            ma_in = prod[31:0];
            if (first_ff) begin
               mb_in = {8'd0, ftime_ff};
               sum_in = 64'd0;
               state_in = rvd_pkg::ST_MULB;
            end else begin
               mb_in = {16'd0, step};
               state_in = rvd_pkg::ST_MULC;
            end
         end
         rvd_pkg::ST_MULB: begin
            acc_in = prod; ma_in = sq_ff[63:32];
            state_in = rvd_pkg::ST_SQ2;
         end
         rvd_pkg::ST_MULC: begin
            acc_in = prod; ma_in = sq_ff[63:32];
            state_in = rvd_pkg::ST_SUM2;
         end
         rvd_pkg::ST_SQ2: begin
            acc_in = acc_ff + {prod[31:0], 32'd0};
            state_in = rvd_pkg::ST_SUM1;
         end
         rvd_pkg::ST_SUM1: begin
            if (!rv_ff) begin
               sum_in = acc_ff;
               elap_in = {8'd0, ftime_ff};
               out_in.rms_velocity = vel_ff; out_in.last_of_run = 1'b0;
               out_in.saturated = sat0_ff; rv_in = 1'b1;
               ma_in = sq_ff[31:0]; mb_in = {16'd0, step};
               state_in = rvd_pkg::ST_MULC;
            end
         end
         rvd_pkg::ST_SUM2: begin
            if (prod[63:32] != 32'd0) begin
               sat_in = 1'b1; sum_in = '1;
            end else begin
               acc_in = acc_ff + {prod[31:0], 32'd0};
               state_in = rvd_pkg::ST_DIFF;
            end
            if (prod[63:32] != 32'd0) state_in = rvd_pkg::ST_DIFF;
            if (prod[63:32] != 32'd0) acc_in = 64'd0;
         end
         rvd_pkg::ST_DIFF: begin
            if (wide_c) begin
               sat_in = 1'b1; sum_in = '1;
            end else begin
               sum_in = wide_sum;
            end
            if (tnext[32]) begin
               sat_in = 1'b1; elap_in = '1;
            end else begin
               elap_in = tnext[31:0];
            end
            state_in = rvd_pkg::ST_DIVT;
            num_in = wide_c ? '1 : wide_sum;
            rem_in = 64'd0; quo_in = 64'd0; cnt_in = 7'd64;
            den_in = tnext[32] ? 64'hFFFF_FFFF :
                     (tnext[31:0] == 32'd0 ? 64'd1 : {32'd0, tnext[31:0]});
         end
         rvd_pkg::ST_DIVT: begin
            if (cnt_ff == 7'd0) begin
               num_in = quo_ff; rem_in = 64'd0; quo_in = 64'd0; cnt_in = 7'd32;
               state_in = rvd_pkg::ST_SQRT;
            end else begin
               cnt_in = cnt_ff - 7'd1;
               num_in = {num_ff[62:0], 1'b0};
               if (!trial[64]) begin
                  rem_in = trial[63:0]; quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[62:0], num_ff[63]}; quo_in = {quo_ff[62:0], 1'b0};
               end
            end
         end
         rvd_pkg::ST_SQRT: begin
            if (cnt_ff == 7'd0) begin
               state_in = rvd_pkg::ST_OUT;
            end else begin
               cnt_in = cnt_ff - 7'd1;
               num_in = {num_ff[61:0], 2'b00};
               if (!sqt[65]) begin
                  rem_in = sqt[63:0]; quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[61:0], num_ff[63:62]}; quo_in = {quo_ff[62:0], 1'b0};
               end
            end
         end
         rvd_pkg::ST_OUT: begin
            if (!rv_ff) begin
               if (quo_ff > 64'(rvd_pkg::VelMax)) begin
                  out_in.rms_velocity = 17'h0FFFF; out_in.saturated = 1'b1;
               end else begin
                  out_in.rms_velocity = quo_ff[16:0]; out_in.saturated = sat_ff;
               end
               out_in.last_of_run = 1'b1; rv_in = 1'b1;
               phase_in = 2'd2; state_in = rvd_pkg::ST_IDLE;
            end
         end
         default: state_in = rvd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rvd_pkg::ST_IDLE; tstep_ff <= 16'd4000; ftime_ff <= 24'd0;
         prev_ff <= 32'd0; sum_ff <= 64'd0; elap_ff <= 32'd0; phase_ff <= 2'd0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; tstep_ff <= tstep_in; ftime_ff <= ftime_in;
         prev_ff <= prev_in; sum_ff <= sum_in; elap_ff <= elap_in;
         phase_ff <= phase_in; rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in; sat_ff <= sat_in; sat0_ff <= sat0_in;
      first_ff <= first_in; vel_ff <= vel_in; sq_ff <= sq_in; acc_ff <= acc_in;
      ma_ff <= ma_in; mb_ff <= mb_in; out_ff <= out_in;
   end
endmodule

FILE: sv/rvd_checker.sv
`include "rms_velocity_from_depth_time_unit_assert.svh"
module rvd_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic last_of_run,
   input logic csr_pready
);
   `RVD_ASSERT_IMP(a_pready, clock, reset, 1'b1, csr_pready)
   `RVD_ASSERT_IMP(a_mid, clock, reset, rsp_valid && !last_of_run, !req_ready)
   `RVD_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `RVD_ASSERT_NEXT(a_stable, clock, reset, rsp_valid && !rsp_ready, $stable(last_of_run))
endmodule

bind rms_velocity_from_depth_time_unit rvd_checker u_rvd_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .last_of_run(rsp.payload[1]), .csr_pready(csr_pready)
);

FILE: dv/rms_velocity_from_depth_time_unit_tb.sv
module rms_velocity_from_depth_time_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      logic [31:0]      depth;
      bit               start;
      int               typed_count;
      rvd_pkg::rsp_type typed0;
      rvd_pkg::rsp_type typed1;
   } depth_row_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   rvd_stream_if #(.W($bits(rvd_pkg::req_type))) req ();
   rvd_stream_if #(.W($bits(rvd_pkg::rsp_type))) rsp ();

   rms_velocity_from_depth_time_unit u_top (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   logic [15:0] cfg_step;
   logic [23:0] cfg_first;
   logic [31:0] prev_depth;
   logic [63:0] vsq_sum;
   logic [31:0] elapsed_us;
   logic [1:0]  trace_phase;

   rvd_pkg::rsp_type velocity_q[$];
   int errors;
   int hold_request;
   bit sender_quiet;
   depth_row_type rows[$];

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      #10ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] sum_clip(logic [63:0] a, logic [63:0] b, inout bit sat);
      if (a > ~64'd0 - b) begin
         sat = 1'b1;
         return ~64'd0;
      end
      return a + b;
   endfunction

   task automatic predict_velocity(input logic [31:0] d, input bit s);
      longint num;
      longint vel;
      longint unsigned mag;
      longint unsigned q;
      longint unsigned dt;
      longint unsigned sq;
      longint unsigned t;
      longint unsigned r;
      bit sat;
      rvd_pkg::rsp_type e;
      if (s || trace_phase == 2'd0 || trace_phase > 2'd2) begin
         prev_depth = d;
         vsq_sum = 0;
         elapsed_us = 0;
         trace_phase = 2'd1;
         return;
      end
      sat = 1'b0;
      dt = (cfg_step == 0) ? 1 : cfg_step;
      num = (longint'($signed(d)) - longint'($signed(prev_depth))) * 2000;
      mag = (num < 0) ? -num : num;
      q = (mag + dt / 2) / dt;
      if (num < 0) begin
         if (q > 65536) begin
            sat = 1'b1;
            vel = -65536;
         end else begin
            vel = -longint'(q);
         end
      end else if (q > 65535) begin
         sat = 1'b1;
         vel = 65535;
      end else begin
         vel = q;
      end
      prev_depth = d;
      sq = (vel < 0) ? -vel : vel;
      sq = sq * sq;
      if (trace_phase == 2'd1) begin
         e.rms_velocity = vel[16:0];
         e.last_of_run = 1'b0;
         e.saturated = sat;
         velocity_q.push_back(e);
         vsq_sum = sum_clip(64'd0, longint'(cfg_first) * sq, sat);
         elapsed_us = {8'd0, cfg_first};
      end
      vsq_sum = sum_clip(vsq_sum, dt * sq, sat);
      t = longint'(elapsed_us) + dt;
      if (t > 64'hFFFF_FFFF) begin
         t = 64'hFFFF_FFFF;
         sat = 1'b1;
      end
      elapsed_us = t[31:0];
      t = (elapsed_us == 0) ? 1 : elapsed_us;
      r = root_floor(vsq_sum / t);
      if (r > rvd_pkg::VelMax) begin
         r = rvd_pkg::VelMax;
         sat = 1'b1;
      end
      e.rms_velocity = r[16:0];
      e.last_of_run = 1'b1;
      e.saturated = sat;
      velocity_q.push_back(e);
      trace_phase = 2'd2;
   endtask

   task automatic csr_write(input logic [0:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == rvd_pkg::REG_TIME_STEP) cfg_step = value[15:0];
      else cfg_first = value[23:0];
   endtask

   task automatic set_timing(input logic [15:0] step, input logic [23:0] first);
      csr_write(rvd_pkg::REG_TIME_STEP, {16'd0, step});
      csr_write(rvd_pkg::REG_FIRST_TIME, {8'd0, first});
   endtask

   task automatic wait_drained();
      while (velocity_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_depth(input logic [31:0] d, input bit s);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= {d, s};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   initial begin
      int stall;
      int quiet_left;
      rvd_pkg::rsp_type got;
      rvd_pkg::rsp_type want;
      quiet_left = 0;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (quiet_left == 0 && $urandom_range(0, 3) == 0) quiet_left = $urandom_range(10, 40);
         stall = (quiet_left > 0) ? 0 : $urandom_range(0, 9);
         if (quiet_left > 0) quiet_left--;
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         got = rvd_pkg::rsp_type'(rsp.payload);
         if (velocity_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %h", $time, got);
         end else begin
            want = velocity_q.pop_front();
            if (got.rms_velocity !== want.rms_velocity || got.last_of_run !== want.last_of_run
                || got.saturated !== want.saturated) begin
               errors++;
               $display("%0t: expected v=%h last=%b sat=%b, got v=%h last=%b sat=%b", $time,
                        want.rms_velocity, want.last_of_run, want.saturated,
                        got.rms_velocity, got.last_of_run, got.saturated);
            end
         end
      end
   end

   initial begin
      logic [15:0] steps[6];
      logic [23:0] firsts[6];
      logic [31:0] d;
      int span;
      int trace_left;
      bit s;
      errors = 0;
      hold_request = 0;
      sender_quiet = 0;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.payload <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      cfg_step = 16'd4000;
      cfg_first = 24'd0;
      prev_depth = 0;
      vsq_sum = 0;
      elapsed_us = 0;
      trace_phase = 2'd0;
      rows = '{
         '{32'd0, 0, 0, '0, '0},
         '{32'd0, 0, 2, '{17'd0, 1'b0, 1'b0}, '{17'd0, 1'b1, 1'b0}},
         '{32'h7FFF_FFFF, 0, -1, '0, '0},
         '{32'h8000_0000, 0, -1, '0, '0},
         '{32'd12345, 0, -1, '0, '0},
         '{32'h8000_0000, 1, 0, '0, '0},
         '{32'h7FFF_FFFF, 0, 2, '{17'h0FFFF, 1'b0, 1'b1}, '{17'h0FFFF, 1'b1, 1'b1}},
         '{32'd0, 1, 0, '0, '0},
         '{32'h8000_0000, 0, 2, '{17'h10000, 1'b0, 1'b1}, '{17'h0FFFF, 1'b1, 1'b1}},
         '{32'h8000_0FA0, 0, -1, '0, '0},
         '{32'd1, 1, 0, '0, '0},
         '{32'd3, 0, -1, '0, '0},
         '{32'd4, 0, -1, '0, '0},
         '{32'd3, 0, -1, '0, '0},
         '{32'hFFFF_FFFF, 0, -1, '0, '0},
         '{32'h5555_5555, 0, -1, '0, '0},
         '{32'hAAAA_AAAA, 0, -1, '0, '0}
      };
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send_depth(rows[i].depth, rows[i].start);
         predict_velocity(rows[i].depth, rows[i].start);
         if (rows[i].typed_count == 2) begin
            void'(velocity_q.pop_back());
            void'(velocity_q.pop_back());
            velocity_q.push_back(rows[i].typed0);
            velocity_q.push_back(rows[i].typed1);
         end
      end
      req.valid <= 1'b0;
      wait_drained();

      steps = '{16'd0, 16'd65535, 16'd1, 16'd4000, 16'($urandom), 16'($urandom_range(1, 9000))};
      firsts = '{24'hFF_FFFF, 24'd0, 24'd0, 24'd1000, 24'($urandom), 24'($urandom_range(0, 99999))};
      foreach (steps[p]) begin
         set_timing(steps[p], firsts[p]);
         sender_quiet = (p % 2 == 1);
         if (p == 2) hold_request = 600;
         trace_left = 0;
         d = prev_depth;
         for (int n = 0; n < 80; n++) begin
            s = 1'b0;
            if (trace_left == 0) begin
               trace_left = $urandom_range(1, 14);
               s = (p == 0 && n == 0) ? 1'b0 : ($urandom_range(0, 4) != 0);
            end else if ($urandom_range(0, 24) == 0) begin
               s = 1'b1;
            end
            trace_left--;
            span = (cfg_step == 0 ? 1 : cfg_step) * 3 + 2;
            case ($urandom_range(0, 9))
               0: d = $urandom;
               1: d = d + ($urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000);
               default: d = d + $urandom_range(0, 2 * span) - span;
            endcase
            send_depth(d, s);
            predict_velocity(d, s);
         end
         req.valid <= 1'b0;
         wait_drained();
      end

      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
